### hw/rtl/owts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owts_pkg
// Shared types and constants of the one-wire temperature sensor master.
// ----------------------------------------------------------------------------
package owts_pkg;

  localparam int ActionWidth = 3;
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth = 16;

  localparam logic [ActionWidth-1:0] ACT_TICK      = 3'd0;
  localparam logic [ActionWidth-1:0] ACT_RESET     = 3'd1;
  localparam logic [ActionWidth-1:0] ACT_WRITE     = 3'd2;
  localparam logic [ActionWidth-1:0] ACT_READ      = 3'd3;
  localparam logic [ActionWidth-1:0] ACT_CONVERT   = 3'd4;
  localparam logic [ActionWidth-1:0] ACT_READ_TEMP = 3'd5;

  localparam logic [CfgIndexWidth-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_RESET_RELEASE = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_POST_GAP      = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_SLOT_SHORT    = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_SLOT_LONG     = 3'd4;

  localparam logic [15:0] RESET_LOW_DEFAULT     = 16'd480;
  localparam logic [15:0] RESET_RELEASE_DEFAULT = 16'd60;
  localparam logic [15:0] POST_GAP_DEFAULT      = 16'd500;
  localparam logic [7:0]  SLOT_SHORT_DEFAULT    = 8'd2;
  localparam logic [7:0]  SLOT_LONG_DEFAULT     = 8'd60;

  localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
  localparam logic [7:0] CMD_CONVERT      = 8'h44;
  localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

  typedef enum logic [8:0] {
    PH_IDLE    = 9'b000000001,
    PH_RST_LOW = 9'b000000010,
    PH_RST_REL = 9'b000000100,
    PH_GAP     = 9'b000001000,
    PH_WR_LOW  = 9'b000010000,
    PH_WR_REL  = 9'b000100000,
    PH_RD_LOW  = 9'b001000000,
    PH_RD_REL  = 9'b010000000,
    PH_RD_REC  = 9'b100000000
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic [15:0]            tick_count;
    logic [2:0]             bit_index;
    logic [7:0]             shift_byte;
    logic [2:0]             sequence_step;
    logic [ActionWidth-1:0] sequence_kind;
  } core_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic [7:0]         read_data;
    logic signed [15:0] temperature_tenths;
  } res_t;

endpackage

### hw/rtl/onewire_temp_sensor_master_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_temp_sensor_master_top
// Tick-driven one-wire master: reset pulse, byte write/read, and the
// start-conversion and read-temperature sequences of a single-drop sensor.
//
// Usage: every input item is one bus tick carrying an action, a byte to
// write and the sampled line level. Commands are taken only while no
// sequence runs; otherwise the action is ignored and the tick just advances
// the running sequence. Each input item yields exactly one result item with
// the open-drain drive, busy and done flags, the last read byte and the last
// temperature in tenths of a degree.
// The result of an accepted input item is registered into the result register,
// or into the skid register while the result register is held; throughput is
// one item per cycle while in_stall is low.
// A two-entry result buffer (result register plus skid register) lets the
// input keep flowing while one result waits; in_stall rises only when both
// entries are full, so stalling the output stalls the input one item later.
// Reset (rst, synchronous) returns the sequencer to idle, clears the read
// byte and temperature, empties the result buffer and loads the default tick
// registers. Configuration writes are always ready and are meant for idle.
// ----------------------------------------------------------------------------
module onewire_temp_sensor_master_top import owts_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ActionWidth-1:0]   action,
  input  logic [7:0]               data_byte,
  input  logic                     line_level,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     drive_low,
  output logic                     busy_res,
  output logic                     done_res,
  output logic [7:0]               read_data,
  output logic signed [15:0]       temperature_tenths,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  logic [15:0] reset_low_ticks;
  logic [15:0] reset_release_ticks;
  logic [15:0] post_reset_gap_ticks;
  logic [7:0]  slot_short_ticks;
  logic [7:0]  slot_long_ticks;

  core_t              core;
  core_t              core_next;
  logic [7:0]         last_read;
  logic [7:0]         last_read_next;
  logic [7:0]         low_temp_byte;
  logic [7:0]         low_temp_byte_next;
  logic [15:0]        temp_result;
  logic [15:0]        temp_result_next;
  res_t               res;
  res_t               head;
  res_t               skid;
  logic               skid_valid;
  logic               in_accept;
  logic               out_pop;

  function automatic logic [15:0] at_least_one16(logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [15:0] at_least_one8(logic [7:0] v);
    return (v == 8'd0) ? 16'd1 : {8'd0, v};
  endfunction

  function automatic logic [15:0] phase_len(core_t s);
    logic [15:0] sh;
    logic [15:0] lg;
    logic [15:0] len;
    sh = at_least_one8(slot_short_ticks);
    lg = at_least_one8(slot_long_ticks);
    case (s.phase)
      PH_RST_LOW: len = at_least_one16(reset_low_ticks);
      PH_RST_REL: len = at_least_one16(reset_release_ticks);
      PH_GAP:     len = post_reset_gap_ticks;
      PH_WR_LOW:  len = s.shift_byte[0] ? sh : lg;
      PH_WR_REL:  len = s.shift_byte[0] ? lg : sh;
      PH_RD_LOW:  len = sh;
      PH_RD_REL:  len = sh;
      PH_RD_REC:  len = lg;
      default:    len = 16'd1;
    endcase
    return len;
  endfunction

  function automatic core_t begin_step(core_t s);
    core_t r;
    r = s;
    r.tick_count = 16'd0;
    r.bit_index = 3'd0;
    r.phase = PH_IDLE;
    case (s.sequence_kind)
      ACT_RESET: begin
        if (s.sequence_step == 3'd0) r.phase = PH_RST_LOW;
      end
      ACT_WRITE: begin
        if (s.sequence_step == 3'd0) r.phase = PH_WR_LOW;
      end
      ACT_READ: begin
        if (s.sequence_step == 3'd0) begin
          r.phase = PH_RD_LOW;
          r.shift_byte = 8'd0;
        end
      end
      ACT_CONVERT: begin
        case (s.sequence_step)
          3'd0: r.phase = PH_RST_LOW;
          3'd1: begin
            r.phase = PH_WR_LOW;
            r.shift_byte = CMD_SKIP_ROM;
          end
          3'd2: begin
            r.phase = PH_WR_LOW;
            r.shift_byte = CMD_CONVERT;
          end
          default: r.phase = PH_IDLE;
        endcase
      end
      ACT_READ_TEMP: begin
        case (s.sequence_step)
          3'd0: r.phase = PH_RST_LOW;
          3'd1: begin
            r.phase = PH_WR_LOW;
            r.shift_byte = CMD_SKIP_ROM;
          end
          3'd2: begin
            r.phase = PH_WR_LOW;
            r.shift_byte = CMD_READ_SCRATCH;
          end
          3'd3, 3'd4: begin
            r.phase = PH_RD_LOW;
            r.shift_byte = 8'd0;
          end
          default: r.phase = PH_IDLE;
        endcase
      end
      default: r.phase = PH_IDLE;
    endcase
    return r;
  endfunction

  function automatic core_t next_step(core_t s);
    core_t r;
    r = s;
    r.sequence_step = s.sequence_step + 3'd1;
    return begin_step(r);
  endfunction

  // raw * 10 / 16 with +8 rounding, truncated toward zero
  function automatic logic [15:0] to_tenths(logic [15:0] u);
    logic signed [20:0] raw;
    logic signed [20:0] v;
    raw = $signed({{5{u[15]}}, u});
    v = (raw <<< 3) + (raw <<< 1) + 21'sd8;
    if (v[20]) begin
      v = v + 21'sd15;
    end
    return v[19:4];
  endfunction

  assign in_accept = in_valid && !in_stall;
  assign out_pop   = out_valid && !out_stall;
  assign in_stall  = skid_valid;
  assign cfg_ready = 1'b1;

  always_comb begin
    core_next = core;
    last_read_next = last_read;
    low_temp_byte_next = low_temp_byte;
    temp_result_next = temp_result;
    res = '0;
    if (core.phase == PH_IDLE && action inside {[ACT_RESET:ACT_READ_TEMP]}) begin
      core_next.sequence_kind = action;
      core_next.sequence_step = 3'd0;
      if (action == ACT_WRITE) begin
        core_next.shift_byte = data_byte;
      end
      core_next = begin_step(core_next);
    end
    if (core_next.phase != PH_IDLE) begin
      res.busy_res = 1'b1;
      res.drive_low = core_next.phase inside {PH_RST_LOW, PH_WR_LOW, PH_RD_LOW};
      core_next.tick_count = core_next.tick_count + 16'd1;
      if (core_next.tick_count >= phase_len(core_next)) begin
        core_next.tick_count = 16'd0;
        case (core_next.phase)
          PH_RST_LOW: core_next.phase = PH_RST_REL;
          PH_RST_REL: begin
            if ((core_next.sequence_kind == ACT_CONVERT ||
                 core_next.sequence_kind == ACT_READ_TEMP) &&
                post_reset_gap_ticks != 16'd0) begin
              core_next.phase = PH_GAP;
            end else begin
              core_next = next_step(core_next);
            end
          end
          PH_GAP: core_next = next_step(core_next);
          PH_WR_LOW: core_next.phase = PH_WR_REL;
          PH_WR_REL: begin
            core_next.shift_byte = {1'b0, core_next.shift_byte[7:1]};
            if (core_next.bit_index == 3'd7) begin
              core_next = next_step(core_next);
            end else begin
              core_next.bit_index = core_next.bit_index + 3'd1;
              core_next.phase = PH_WR_LOW;
            end
          end
          PH_RD_LOW: core_next.phase = PH_RD_REL;
          PH_RD_REL: begin
            core_next.shift_byte = {line_level, core_next.shift_byte[7:1]};
            core_next.phase = PH_RD_REC;
          end
          PH_RD_REC: begin
            if (core_next.bit_index == 3'd7) begin
              last_read_next = core_next.shift_byte;
              if (core_next.sequence_kind == ACT_READ_TEMP) begin
                if (core_next.sequence_step == 3'd3) begin
                  low_temp_byte_next = core_next.shift_byte;
                end
                if (core_next.sequence_step == 3'd4) begin
                  temp_result_next = to_tenths({core_next.shift_byte, low_temp_byte});
                end
              end
              core_next = next_step(core_next);
            end else begin
              core_next.bit_index = core_next.bit_index + 3'd1;
              core_next.phase = PH_RD_LOW;
            end
          end
          default: core_next.phase = PH_IDLE;
        endcase
        res.done_res = (core_next.phase == PH_IDLE);
      end
    end
    res.read_data = last_read_next;
    res.temperature_tenths = temp_result_next;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      core.phase <= PH_IDLE;
      core.tick_count <= 16'd0;
      core.bit_index <= 3'd0;
      core.shift_byte <= 8'd0;
      core.sequence_step <= 3'd0;
      core.sequence_kind <= ACT_TICK;
      last_read <= 8'd0;
      low_temp_byte <= 8'd0;
      temp_result <= 16'd0;
    end else if (in_accept) begin
      core <= core_next;
      last_read <= last_read_next;
      low_temp_byte <= low_temp_byte_next;
      temp_result <= temp_result_next;
    end
  end

  // tick registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_ticks <= RESET_LOW_DEFAULT;
      reset_release_ticks <= RESET_RELEASE_DEFAULT;
      post_reset_gap_ticks <= POST_GAP_DEFAULT;
      slot_short_ticks <= SLOT_SHORT_DEFAULT;
      slot_long_ticks <= SLOT_LONG_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RESET_LOW:     reset_low_ticks <= cfg_data;
        REG_RESET_RELEASE: reset_release_ticks <= cfg_data;
        REG_POST_GAP:      post_reset_gap_ticks <= cfg_data;
        REG_SLOT_SHORT:    slot_short_ticks <= cfg_data[7:0];
        REG_SLOT_LONG:     slot_long_ticks <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // result register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_pop) begin
        head <= skid;
        skid_valid <= 1'b0;
      end
    end else if (in_accept) begin
      if (!out_valid || out_pop) begin
        head <= res;
        out_valid <= 1'b1;
      end else begin
        skid <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  assign drive_low          = head.drive_low;
  assign busy_res           = head.busy_res;
  assign done_res           = head.done_res;
  assign read_data          = head.read_data;
  assign temperature_tenths = head.temperature_tenths;

endmodule

### hw/rtl/owts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owts_checker
// Port-level checks of the one-wire temperature sensor master.
// ----------------------------------------------------------------------------
module owts_checker import owts_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               drive_low,
  input logic               busy_res,
  input logic               done_res,
  input logic [7:0]         read_data,
  input logic signed [15:0] temperature_tenths
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> busy_res)
    else $error("done item without busy");

  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> !drive_low)
    else $error("line driven while idle");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty result register");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(drive_low) && $stable(busy_res)
      && $stable(done_res) && $stable(read_data) && $stable(temperature_tenths))
    else $error("stalled item changed");

endmodule

bind onewire_temp_sensor_master_top owts_checker u_owts_checker (
  .clk(clk),
  .rst(rst),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .drive_low(drive_low),
  .busy_res(busy_res),
  .done_res(done_res),
  .read_data(read_data),
  .temperature_tenths(temperature_tenths)
);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for onewire_temp_sensor_master_top: bus ticks in, one result out.
//
// A queue of pending bus ticks feeds a clocked driver. Every accepted tick
// runs through a cycle-accurate model of the sequencer, whose result is
// queued and compared field by field with the block's output by a clocked
// monitor. A simple sensor model answers read slots with the bits of a chosen
// 16-bit word, so byte and temperature reads return known values. Both sides
// idle in random bursts. The tick registers go through the reset defaults,
// zero and one, random small values, all-max and a short-over-long setting,
// some of them changed while a sequence is running.
// ----------------------------------------------------------------------------
module tb;
  import owts_pkg::*;

  localparam logic [2:0] ACT_UNUSED6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED7 = 3'd7;
  localparam int QUIET_LIMIT = 2000;

  typedef enum logic [1:0] {OP_RESET, OP_WRITE, OP_READ, OP_END} bus_op_t;

  typedef struct {
    logic [2:0]  act;
    logic [7:0]  data;
    logic        line;
    logic [15:0] sensor_word;
    bit          fill;
    bit          noisy;
    bit          sensor;
  } tick_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ActionWidth-1:0] action = '0;
  logic [7:0] data_byte = '0;
  logic line_level = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic drive_low;
  logic busy_res;
  logic done_res;
  logic [7:0] read_data;
  logic signed [15:0] temperature_tenths;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  onewire_temp_sensor_master_top u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .data_byte(data_byte),
    .line_level(line_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .drive_low(drive_low),
    .busy_res(busy_res),
    .done_res(done_res),
    .read_data(read_data),
    .temperature_tenths(temperature_tenths),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow tick registers
  logic [15:0] low_len = RESET_LOW_DEFAULT;
  logic [15:0] rel_len = RESET_RELEASE_DEFAULT;
  logic [15:0] gap_len = POST_GAP_DEFAULT;
  logic [7:0] short_len = SLOT_SHORT_DEFAULT;
  logic [7:0] long_len = SLOT_LONG_DEFAULT;

  // sequencer model state
  phase_t bus_phase = PH_IDLE;
  logic [15:0] phase_ticks = '0;
  logic [2:0] bit_pos = '0;
  logic [7:0] shift_reg = '0;
  logic [2:0] seq_step = '0;
  logic [2:0] seq_kind = '0;
  logic [7:0] temp_lo = '0;
  logic [7:0] last_byte = '0;
  logic [15:0] tenths_q = '0;
  bit seq_done = 1'b0;

  tick_item_t tick_q[$];
  res_t predicted_res[$];
  int queued_items = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit idle_on = 1'b1;
  int fails = 0;
  int quiet = 0;
  int n_ticks = 0;
  int n_started = 0;
  int n_done = 0;
  int n_temps = 0;

  function automatic logic [15:0] min_one(logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [15:0] phase_length();
    logic [15:0] s_len, l_len;
    s_len = min_one({8'd0, short_len});
    l_len = min_one({8'd0, long_len});
    case (bus_phase)
      PH_RST_LOW: return min_one(low_len);
      PH_RST_REL: return min_one(rel_len);
      PH_GAP:     return gap_len;
      PH_WR_LOW:  return shift_reg[0] ? s_len : l_len;
      PH_WR_REL:  return shift_reg[0] ? l_len : s_len;
      PH_RD_LOW,
      PH_RD_REL:  return s_len;
      PH_RD_REC:  return l_len;
      default:    return 16'd1;
    endcase
  endfunction

  function automatic void start_step();
    bus_op_t op;
    logic [7:0] wbyte;
    op = OP_END;
    wbyte = shift_reg;
    case (seq_kind)
      ACT_RESET: if (seq_step == 3'd0) op = OP_RESET;
      ACT_WRITE: if (seq_step == 3'd0) op = OP_WRITE;
      ACT_READ:  if (seq_step == 3'd0) op = OP_READ;
      ACT_CONVERT, ACT_READ_TEMP: begin
        case (seq_step)
          3'd0: op = OP_RESET;
          3'd1: begin
            op = OP_WRITE;
            wbyte = CMD_SKIP_ROM;
          end
          3'd2: begin
            op = OP_WRITE;
            wbyte = (seq_kind == ACT_CONVERT) ? CMD_CONVERT : CMD_READ_SCRATCH;
          end
          3'd3, 3'd4: if (seq_kind == ACT_READ_TEMP) op = OP_READ;
          default: ;
        endcase
      end
      default: ;
    endcase
    phase_ticks = '0;
    bit_pos = '0;
    case (op)
      OP_RESET: bus_phase = PH_RST_LOW;
      OP_WRITE: begin
        shift_reg = wbyte;
        bus_phase = PH_WR_LOW;
      end
      OP_READ: begin
        shift_reg = '0;
        bus_phase = PH_RD_LOW;
      end
      default: begin
        bus_phase = PH_IDLE;
        seq_done = 1'b1;
      end
    endcase
  endfunction

  function automatic void next_step();
    seq_step = seq_step + 3'd1;
    start_step();
  endfunction

  function automatic void end_phase(logic line);
    int raw;
    phase_ticks = '0;
    case (bus_phase)
      PH_RST_LOW: bus_phase = PH_RST_REL;
      PH_RST_REL: begin
        if ((seq_kind == ACT_CONVERT || seq_kind == ACT_READ_TEMP) && gap_len != 16'd0)
          bus_phase = PH_GAP;
        else
          next_step();
      end
      PH_GAP: next_step();
      PH_WR_LOW: bus_phase = PH_WR_REL;
      PH_WR_REL: begin
        shift_reg = shift_reg >> 1;
        if (bit_pos == 3'd7) begin
          next_step();
        end else begin
          bit_pos = bit_pos + 3'd1;
          bus_phase = PH_WR_LOW;
        end
      end
      PH_RD_LOW: bus_phase = PH_RD_REL;
      PH_RD_REL: begin
        shift_reg = {line, shift_reg[7:1]};
        bus_phase = PH_RD_REC;
      end
      PH_RD_REC: begin
        if (bit_pos == 3'd7) begin
          last_byte = shift_reg;
          if (seq_kind == ACT_READ_TEMP && seq_step == 3'd3) temp_lo = shift_reg;
          if (seq_kind == ACT_READ_TEMP && seq_step == 3'd4) begin
            // sixteenths to tenths, rounded, truncated toward zero
            raw = $signed({shift_reg, temp_lo});
            tenths_q = 16'((raw * 10 + 8) / 16);
            n_temps++;
          end
          next_step();
        end else begin
          bit_pos = bit_pos + 3'd1;
          bus_phase = PH_RD_LOW;
        end
      end
      default: bus_phase = PH_IDLE;
    endcase
  endfunction

  function automatic res_t bus_tick(logic [2:0] act, logic [7:0] data, logic line);
    res_t r;
    r = '0;
    seq_done = 1'b0;
    n_ticks++;
    if (bus_phase == PH_IDLE && act >= ACT_RESET && act <= ACT_READ_TEMP) begin
      seq_kind = act;
      seq_step = '0;
      if (act == ACT_WRITE) shift_reg = data;
      n_started++;
      start_step();
    end
    if (bus_phase != PH_IDLE) begin
      r.busy_res = 1'b1;
      r.drive_low = (bus_phase == PH_RST_LOW || bus_phase == PH_WR_LOW ||
                     bus_phase == PH_RD_LOW);
      phase_ticks = phase_ticks + 16'd1;
      if (phase_ticks >= phase_length()) end_phase(line);
    end
    if (seq_done) n_done++;
    r.done_res = seq_done;
    r.read_data = last_byte;
    r.temperature_tenths = tenths_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  // driver: one tick item per handshake
  always @(posedge clk) begin : feed
    tick_item_t it;
    logic [3:0] bsel;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_res.push_back(bus_tick(action, data_byte, line_level));
      end
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          it = tick_q.pop_front();
          if (it.fill) begin
            // commands while busy must be ignored
            if (bus_phase != PH_IDLE || (it.noisy && $urandom_range(0, 31) == 0)) begin
              it.act = 3'($urandom_range(0, 7));
            end else begin
              case ($urandom_range(0, 2))
                0: it.act = ACT_TICK;
                1: it.act = ACT_UNUSED6;
                default: it.act = ACT_UNUSED7;
              endcase
            end
          end
          // sensor answers with the bit the next read slot samples
          bsel = {(seq_kind == ACT_READ_TEMP && seq_step == 3'd4), bit_pos};
          action <= it.act;
          data_byte <= it.data;
          line_level <= it.sensor ? it.sensor_word[bsel] : it.line;
          in_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 15) == 0) in_gap = $urandom_range(1, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result item with the oldest prediction
  always @(posedge clk) begin : sink
    res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_res.size() == 0) begin
          $display("%0t ns: result item with nothing expected", $time);
          fails++;
        end else begin
          want = predicted_res.pop_front();
          check_field("drive_low", want.drive_low, drive_low);
          check_field("busy_res", want.busy_res, busy_res);
          check_field("done_res", want.done_res, done_res);
          check_field("read_data", want.read_data, read_data);
          check_field("temperature_tenths", $signed(want.temperature_tenths),
                      temperature_tenths);
        end
      end
      if (out_gap != 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (idle_on && $urandom_range(0, 15) == 0) out_gap = $urandom_range(1, 10);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t ns: timeout, no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL onewire_temp_sensor_master_top");
        $finish;
      end
    end
  end

  task automatic push_tick(logic [2:0] act, logic [7:0] data, logic [15:0] word,
                           bit fill, bit noisy);
    tick_item_t it;
    it.act = act;
    it.data = data;
    it.sensor_word = word;
    it.fill = fill;
    it.noisy = noisy;
    it.line = 1'($urandom_range(0, 1));
    it.sensor = !noisy || ($urandom_range(0, 7) != 0);
    tick_q.push_back(it);
    queued_items++;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_valid || predicted_res.size() != 0);
  endtask

  task automatic finish_command(logic [15:0] word, bit noisy, int chunk);
    do begin
      repeat (chunk) push_tick(ACT_TICK, 8'($urandom), word, 1'b1, noisy);
      drain();
    end while (bus_phase != PH_IDLE);
  endtask

  task automatic run_command(logic [2:0] act, logic [7:0] data, logic [15:0] word,
                             bit noisy, int chunk);
    push_tick(act, data, word, 1'b0, noisy);
    finish_command(word, noisy, chunk);
  endtask

  task automatic cfg_write(logic [CfgIndexWidth-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RESET_LOW:     low_len = val;
      REG_RESET_RELEASE: rel_len = val;
      REG_POST_GAP:      gap_len = val;
      REG_SLOT_SHORT:    short_len = val[7:0];
      REG_SLOT_LONG:     long_len = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [15:0] low, logic [15:0] rel, logic [15:0] gap,
                          logic [7:0] short_v, logic [7:0] long_v);
    repeat (2) @(posedge clk);
    cfg_write(REG_RESET_LOW, low);
    cfg_write(REG_RESET_RELEASE, rel);
    cfg_write(REG_POST_GAP, gap);
    cfg_write(REG_SLOT_SHORT, {8'd0, short_v});
    cfg_write(REG_SLOT_LONG, {8'd0, long_v});
  endtask

  task automatic random_phase(int n);
    int stop_at;
    logic [2:0] act;
    logic [15:0] word;
    stop_at = queued_items + n;
    while (queued_items < stop_at) begin
      if ($urandom_range(0, 7) == 0) act = 3'($urandom_range(0, 7));
      else act = 3'($urandom_range(ACT_RESET, ACT_READ_TEMP));
      case ($urandom_range(0, 5))
        0: word = 16'h8000;
        1: word = 16'h7FFF;
        2: word = 16'hFFFF;
        default: word = 16'($urandom);
      endcase
      run_command(act, 8'($urandom), word, 1'b1, 16);
    end
  endtask

  initial begin
    logic [15:0] corner_words [4];
    corner_words = '{16'h8000, 16'h7FFF, 16'hFFF8, 16'h0008};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset defaults
    push_tick(ACT_TICK, 8'h00, 16'h0000, 1'b0, 1'b0);
    push_tick(ACT_UNUSED6, 8'hFF, 16'h0000, 1'b0, 1'b0);
    push_tick(ACT_UNUSED7, 8'hFF, 16'h0000, 1'b0, 1'b0);
    push_tick(ACT_READ_TEMP, 8'h00, 16'h0191, 1'b0, 1'b0);
    repeat (39) push_tick(ACT_TICK, 8'($urandom), 16'h0191, 1'b1, 1'b0);
    drain();

    // zero lengths act as one, no gap, lengths shrink under a running phase
    set_regs(16'd0, 16'd1, 16'd0, 8'd0, 8'd1);
    finish_command(16'h0191, 1'b0, 16);
    foreach (corner_words[i]) run_command(ACT_READ_TEMP, 8'h00, corner_words[i], 1'b0, 4);
    run_command(ACT_WRITE, 8'h5A, 16'h0000, 1'b0, 4);
    random_phase(80);

    set_regs(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
             16'($urandom_range(0, 8)), 8'($urandom_range(1, 2)),
             8'($urandom_range(1, 4)));
    random_phase(80);

    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    push_tick(ACT_READ, 8'h00, 16'h8001, 1'b0, 1'b0);
    repeat (29) push_tick(ACT_TICK, 8'($urandom), 16'h8001, 1'b1, 1'b0);
    drain();

    // last part without idling, short slot longer than long slot
    idle_on = 1'b0;
    set_regs(16'd2, 16'd1, 16'd1, 8'd3, 8'd1);
    finish_command(16'h8001, 1'b0, 16);
    random_phase(40);

    drain();
    repeat (5) @(posedge clk);
    $display("%0d ticks checked, %0d sequences started, %0d completed, %0d temperature reads",
             n_ticks, n_started, n_done, n_temps);
    $display("tick registers: defaults, zero and one, random small, all max, short over long");
    if (fails == 0) $display("PASS onewire_temp_sensor_master_top");
    else $display("FAIL onewire_temp_sensor_master_top");
    $finish;
  end

endmodule
